// ----- rtl/apa_pkg.sv -----
// Shared types, codes and constants of the pitch averager.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package apa_pkg;

   typedef logic signed [31:0] corr_type;
   typedef logic [8:0]         idx_type;
   typedef logic [17:0]        rate_type;
   typedef logic [18:0]        upper_type;
   typedef logic [7:0]         byte_type;
   typedef logic [25:0]        div_dend_type;
   typedef logic [8:0]         div_dvs_type;

   localparam int DIV_STEPS = 26;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam rate_type RESET_SAMPLE_RATE = 18'd8000;
   localparam byte_type RESET_THRESHOLD   = 8'd6;
   localparam byte_type RESET_FRAMES      = 8'd50;

   // register indexes, word address bits [3:2]
   localparam logic [1:0] REG_SAMPLE_RATE = 2'd0;
   localparam logic [1:0] REG_THRESHOLD   = 2'd1;
   localparam logic [1:0] REG_FRAMES      = 2'd2;

   typedef enum logic [2:0] {
      PH_FIRST_PEAK,
      PH_FALL,
      PH_RISE,
      PH_SECOND_PEAK,
      PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      ST_SCAN,
      ST_PITCH_START,
      ST_PITCH_WAIT,
      ST_ACCUM,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_BAND_START,
      ST_BAND_WAIT,
      ST_LOAD
   } state_type;

   typedef enum logic [1:0] {
      DIV_PITCH,
      DIV_MEAN,
      DIV_BAND
   } div_sel_type;

   typedef struct packed {
      logic        scan_en;
      logic        frame_close;
      logic        div_start;
      div_sel_type div_sel;
      logic        pitch_zero;
      logic        pitch_load;
      logic        accum;
      logic        mean_load;
      logic        band_zero;
      logic        band_load;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic dist_zero;
      logic td_zero;
      logic window;
      logic div_busy;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/apa_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared by all frame divisions.
// Depends on apa_pkg for operand widths and step count.
`timescale 1ns / 1ps
`default_nettype none
module apa_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire apa_pkg::div_dend_type dividend,
   input  wire apa_pkg::div_dvs_type  divisor,
   output apa_pkg::div_dend_type      quotient,
   output logic                       busy,
   output logic                       done
);

   localparam int CntW = apa_pkg::DIV_CNT_W;
   localparam logic [CntW-1:0] CntLast = CntW'(apa_pkg::DIV_STEPS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   apa_pkg::div_dend_type quo_ff, quo_in;
   apa_pkg::div_dvs_type  rem_ff, rem_in;
   apa_pkg::div_dvs_type  dvs_ff, dvs_in;
   logic [9:0]            trial;
   logic                  fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[apa_pkg::DIV_STEPS-1]};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[apa_pkg::DIV_STEPS-2:0], fits};
         rem_in = fits ? 9'(trial - {1'b0, dvs_ff}) : trial[8:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntLast) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

// ----- rtl/apa_datapath.sv -----
// Datapath: peak scan registers, frame accumulator, shared divider, result register.
// Depends on apa_pkg and apa_divider; driven by commands from apa_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module apa_datapath #(
   parameter int FRAME_LENGTH = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire apa_pkg::cmd_type     cmd,
   output apa_pkg::status_type       status,
   input  wire apa_pkg::rate_type    sample_rate,
   input  wire apa_pkg::byte_type    threshold_divisor,
   input  wire apa_pkg::byte_type    frames_to_average,
   input  wire apa_pkg::corr_type    corr_value,
   output apa_pkg::rate_type         pitch_hz,
   output logic                      distance_error,
   output logic                      mean_valid,
   output apa_pkg::rate_type         mean_pitch,
   output apa_pkg::upper_type        upper_bound,
   output apa_pkg::rate_type         lower_bound
);

   localparam apa_pkg::idx_type IdxStart = apa_pkg::idx_type'(FRAME_LENGTH - 1);

   apa_pkg::phase_type    phase_ff, phase_in, phase_scan;
   apa_pkg::corr_type     peak_ff, peak_in, peak_scan;
   apa_pkg::idx_type      index_ff, index_in;
   apa_pkg::idx_type      first_ff, first_in, first_scan;
   apa_pkg::idx_type      second_ff, second_in, second_scan;
   apa_pkg::idx_type      pos;
   apa_pkg::idx_type      dist_ff, dist_in;
   apa_pkg::div_dend_type sum_ff, sum_in;
   apa_pkg::byte_type     count_ff, count_in, count_plus;
   apa_pkg::rate_type     pitch_ff, mean_ff, band_ff;
   logic                  err_ff, window_ff;

   apa_pkg::rate_type     out_pitch_ff, out_mean_ff, out_lower_ff;
   apa_pkg::upper_type    out_upper_ff;
   logic                  out_err_ff, out_mvalid_ff;

   apa_pkg::div_dend_type div_dend, div_quo;
   apa_pkg::div_dvs_type  div_dvs;
   logic                  div_busy, div_done;

   // one step of the peak scan on the current value
   always_comb begin
      pos         = index_ff + 1'b1;
      phase_scan  = phase_ff;
      peak_scan   = peak_ff;
      first_scan  = first_ff;
      second_scan = second_ff;
      unique case (phase_ff)
         apa_pkg::PH_FIRST_PEAK: begin
            if (corr_value > peak_ff) begin
               peak_scan = corr_value;
            end else begin
               first_scan = pos;
               phase_scan = apa_pkg::PH_FALL;
            end
         end
         apa_pkg::PH_FALL: begin
            if (corr_value < 0) phase_scan = apa_pkg::PH_RISE;
         end
         apa_pkg::PH_RISE: begin
            if (corr_value > 0) begin
               phase_scan = apa_pkg::PH_SECOND_PEAK;
               peak_scan  = '0;
            end
         end
         apa_pkg::PH_SECOND_PEAK: begin
            if (corr_value > peak_ff) begin
               peak_scan = corr_value;
            end else begin
               second_scan = pos;
               phase_scan  = apa_pkg::PH_DONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      peak_in   = peak_ff;
      index_in  = index_ff;
      first_in  = first_ff;
      second_in = second_ff;
      dist_in   = dist_ff;
      if (cmd.frame_close) begin
         // latch distance, then start the next frame
         dist_in   = (first_scan >= second_scan) ? first_scan - second_scan : '0;
         phase_in  = apa_pkg::PH_FIRST_PEAK;
         peak_in   = '0;
         index_in  = IdxStart;
         first_in  = '0;
         second_in = '0;
      end else if (cmd.scan_en) begin
         phase_in  = phase_scan;
         peak_in   = peak_scan;
         first_in  = first_scan;
         second_in = second_scan;
         index_in  = (index_ff != '0) ? index_ff - 1'b1 : index_ff;
      end
   end

   assign count_plus = count_ff + 1'b1;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (cmd.accum) begin
         sum_in   = sum_ff + apa_pkg::div_dend_type'(pitch_ff);
         count_in = count_plus;
      end else if (cmd.out_load && window_ff) begin
         sum_in   = '0;
         count_in = '0;
      end
   end

   always_comb begin
      unique case (cmd.div_sel)
         apa_pkg::DIV_PITCH: begin
            div_dend = apa_pkg::div_dend_type'(sample_rate);
            div_dvs  = dist_ff;
         end
         apa_pkg::DIV_MEAN: begin
            div_dend = sum_ff;
            div_dvs  = apa_pkg::div_dvs_type'(count_ff);
         end
         apa_pkg::DIV_BAND: begin
            div_dend = apa_pkg::div_dend_type'(mean_ff);
            div_dvs  = apa_pkg::div_dvs_type'(threshold_divisor);
         end
         default: begin
            div_dend = '0;
            div_dvs  = '0;
         end
      endcase
   end

   apa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dend),
      .divisor  (div_dvs),
      .quotient (div_quo),
      .busy     (div_busy),
      .done     (div_done)
   );

   always_comb begin
      status.dist_zero = (dist_ff == '0);
      status.td_zero   = (threshold_divisor == '0);
      status.window    = (count_plus >= frames_to_average) && (count_plus != '0);
      status.div_busy  = div_busy;
      status.div_done  = div_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= apa_pkg::PH_FIRST_PEAK;
         peak_ff   <= '0;
         index_ff  <= IdxStart;
         first_ff  <= '0;
         second_ff <= '0;
         sum_ff    <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         peak_ff   <= peak_in;
         index_ff  <= index_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      if (cmd.pitch_zero) begin
         pitch_ff <= '0;
         err_ff   <= 1'b1;
      end else if (cmd.pitch_load) begin
         pitch_ff <= div_quo[17:0];
         err_ff   <= 1'b0;
      end
      if (cmd.accum) window_ff <= status.window;
      if (cmd.mean_load) mean_ff <= div_quo[17:0];
      if (cmd.band_zero) begin
         band_ff <= '0;
      end else if (cmd.band_load) begin
         band_ff <= div_quo[17:0];
      end
      if (cmd.out_load) begin
         out_pitch_ff  <= pitch_ff;
         out_err_ff    <= err_ff;
         out_mvalid_ff <= window_ff;
         out_mean_ff   <= window_ff ? mean_ff : '0;
         out_upper_ff  <= window_ff ? {1'b0, mean_ff} + {1'b0, band_ff} : '0;
         out_lower_ff  <= window_ff ? mean_ff - band_ff : '0;
      end
   end

   assign pitch_hz       = out_pitch_ff;
   assign distance_error = out_err_ff;
   assign mean_valid     = out_mvalid_ff;
   assign mean_pitch     = out_mean_ff;
   assign upper_bound    = out_upper_ff;
   assign lower_bound    = out_lower_ff;

endmodule
`default_nettype wire

// ----- rtl/apa_ctrl.sv -----
// Controller: sequences scan, divisions, accumulation and result hand-off.
// Depends on apa_pkg; issues commands to apa_datapath and reads its status.
`timescale 1ns / 1ps
`default_nettype none
module apa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_frame_end,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire apa_pkg::status_type status,
   output apa_pkg::cmd_type         cmd
);

   apa_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               slot_free;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         apa_pkg::ST_SCAN: begin
            if (accept && req_frame_end) state_in = apa_pkg::ST_PITCH_START;
         end
         apa_pkg::ST_PITCH_START: begin
            state_in = status.dist_zero ? apa_pkg::ST_ACCUM : apa_pkg::ST_PITCH_WAIT;
         end
         apa_pkg::ST_PITCH_WAIT: begin
            if (status.div_done) state_in = apa_pkg::ST_ACCUM;
         end
         apa_pkg::ST_ACCUM: begin
            state_in = status.window ? apa_pkg::ST_MEAN_START : apa_pkg::ST_LOAD;
         end
         apa_pkg::ST_MEAN_START: begin
            state_in = apa_pkg::ST_MEAN_WAIT;
         end
         apa_pkg::ST_MEAN_WAIT: begin
            if (status.div_done) state_in = apa_pkg::ST_BAND_START;
         end
         apa_pkg::ST_BAND_START: begin
            state_in = status.td_zero ? apa_pkg::ST_LOAD : apa_pkg::ST_BAND_WAIT;
         end
         apa_pkg::ST_BAND_WAIT: begin
            if (status.div_done) state_in = apa_pkg::ST_LOAD;
         end
         apa_pkg::ST_LOAD: begin
            if (slot_free) state_in = apa_pkg::ST_SCAN;
         end
         default: begin
            state_in = apa_pkg::ST_SCAN;
         end
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.div_sel = apa_pkg::DIV_PITCH;
      req_ready   = 1'b0;
      unique case (state_ff)
         apa_pkg::ST_SCAN: begin
            req_ready       = 1'b1;
            cmd.scan_en     = req_valid;
            cmd.frame_close = req_valid && req_frame_end;
         end
         apa_pkg::ST_PITCH_START: begin
            cmd.pitch_zero = status.dist_zero;
            cmd.div_start  = !status.dist_zero;
         end
         apa_pkg::ST_PITCH_WAIT: begin
            cmd.pitch_load = status.div_done;
         end
         apa_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
         end
         apa_pkg::ST_MEAN_START: begin
            cmd.div_sel   = apa_pkg::DIV_MEAN;
            cmd.div_start = 1'b1;
         end
         apa_pkg::ST_MEAN_WAIT: begin
            cmd.div_sel   = apa_pkg::DIV_MEAN;
            cmd.mean_load = status.div_done;
         end
         apa_pkg::ST_BAND_START: begin
            cmd.div_sel   = apa_pkg::DIV_BAND;
            cmd.band_zero = status.td_zero;
            cmd.div_start = !status.td_zero;
         end
         apa_pkg::ST_BAND_WAIT: begin
            cmd.div_sel   = apa_pkg::DIV_BAND;
            cmd.band_load = status.div_done;
         end
         apa_pkg::ST_LOAD: begin
            cmd.out_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   // hold the result until taken; a new load replaces it in the same cycle
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= apa_pkg::ST_SCAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before taken");

   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider started while busy");

   a_stall_after_frame: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_frame_end) |=> !req_ready)
      else $error("input taken during frame-end processing");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == apa_pkg::ST_PITCH_WAIT ||
                           state_ff == apa_pkg::ST_MEAN_WAIT ||
                           state_ff == apa_pkg::ST_BAND_WAIT))
      else $error("divider finished outside a wait state");

endmodule
`default_nettype wire

// ----- rtl/autocorr_pitch_averager_unit.sv -----
// Autocorrelation pitch averager: one value per cycle while scanning a frame.
// A frame-end transaction gives its result after the 26-step shared divider has run
// once for the pitch (skipped for a zero distance) and, when it closes a window,
// also for the mean and for the band (skipped for a zero divisor).
// No input is taken until the result is in the output register.
// Reset is synchronous: configuration returns to 8000 Hz, divisor 6, 50 frames.
`timescale 1ns / 1ps
`default_nettype none
module autocorr_pitch_averager_unit #(
   parameter int FRAME_LENGTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [31:0]       req_corr_value,
   input  wire logic                     req_frame_end,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [17:0]                   rsp_pitch_hz,
   output logic                          rsp_distance_error,
   output logic                          rsp_mean_valid,
   output logic [17:0]                   rsp_mean_pitch,
   output logic [18:0]                   rsp_upper_bound,
   output logic [17:0]                   rsp_lower_bound,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [3:0]               paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   apa_pkg::rate_type   sample_rate_ff, sample_rate_in;
   apa_pkg::byte_type   threshold_ff, threshold_in;
   apa_pkg::byte_type   frames_ff, frames_in;
   logic                csr_write;
   apa_pkg::cmd_type    cmd;
   apa_pkg::status_type status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      sample_rate_in = sample_rate_ff;
      threshold_in   = threshold_ff;
      frames_in      = frames_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            apa_pkg::REG_SAMPLE_RATE: sample_rate_in = pwdata[17:0];
            apa_pkg::REG_THRESHOLD:   threshold_in   = pwdata[7:0];
            apa_pkg::REG_FRAMES:      frames_in      = pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         apa_pkg::REG_SAMPLE_RATE: prdata = 32'(sample_rate_ff);
         apa_pkg::REG_THRESHOLD:   prdata = 32'(threshold_ff);
         apa_pkg::REG_FRAMES:      prdata = 32'(frames_ff);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= apa_pkg::RESET_SAMPLE_RATE;
         threshold_ff   <= apa_pkg::RESET_THRESHOLD;
         frames_ff      <= apa_pkg::RESET_FRAMES;
      end else begin
         sample_rate_ff <= sample_rate_in;
         threshold_ff   <= threshold_in;
         frames_ff      <= frames_in;
      end
   end

   apa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_frame_end (req_frame_end),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   apa_datapath #(
      .FRAME_LENGTH (FRAME_LENGTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .sample_rate       (sample_rate_ff),
      .threshold_divisor (threshold_ff),
      .frames_to_average (frames_ff),
      .corr_value        (req_corr_value),
      .pitch_hz          (rsp_pitch_hz),
      .distance_error    (rsp_distance_error),
      .mean_valid        (rsp_mean_valid),
      .mean_pitch        (rsp_mean_pitch),
      .upper_bound       (rsp_upper_bound),
      .lower_bound       (rsp_lower_bound)
   );

endmodule
`default_nettype wire

// ----- bench/autocorr_pitch_averager_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for autocorr_pitch_averager_unit: a directed frame table,
// then random frames under several register settings and handshake idling mixes.
// Depends on apa_pkg and the block's RTL only.
module autocorr_pitch_averager_unit_tb;

   localparam int FRAME_LEN     = 256;
   localparam int ITEM_TARGET   = 1550;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 600;
   localparam int N_DIRECTED    = 22;

   typedef struct packed {
      apa_pkg::rate_type  pitch;
      logic               err;
      logic               mean_ok;
      apa_pkg::rate_type  mean;
      apa_pkg::upper_type upper;
      apa_pkg::rate_type  lower;
   } pitch_report_type;

   typedef struct packed {
      apa_pkg::corr_type value;
      logic              last;
      logic              typed;
      apa_pkg::rate_type pitch;
      logic              err;
   } stim_row_type;

   // Reset settings: 8000 Hz, divisor 6, 50 frames; no window completes here.
   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      // positive lone value: no peak position at all, zero distance
      '{32'h7FFF_FFFF, 1'b1, 1'b1, 18'd0,  1'b1},
      // first peak at the top lag, second missing: 8000 / 256
      '{32'h8000_0000, 1'b1, 1'b1, 18'd31, 1'b0},
      '{32'sd0,        1'b1, 1'b1, 18'd31, 1'b0},
      // all four phases, then an ignored tail
      '{32'sd10,       1'b0, 1'b0, 18'd0,  1'b0},
      '{32'sd20,       1'b0, 1'b0, 18'd0,  1'b0},
      '{32'sd5,        1'b0, 1'b0, 18'd0,  1'b0},
      '{-32'sd1,       1'b0, 1'b0, 18'd0,  1'b0},
      '{32'sd3,        1'b0, 1'b0, 18'd0,  1'b0},
      '{32'sd7,        1'b0, 1'b0, 18'd0,  1'b0},
      '{32'sd2,        1'b0, 1'b0, 18'd0,  1'b0},
      '{32'h7FFF_FFFF, 1'b1, 1'b0, 18'd0,  1'b0},
      // zeros neither fall below nor rise above zero
      '{32'sd5,        1'b0, 1'b0, 18'd0,  1'b0},
      '{32'sd0,        1'b0, 1'b0, 18'd0,  1'b0},
      '{32'sd0,        1'b0, 1'b0, 18'd0,  1'b0},
      '{-32'sd3,       1'b0, 1'b0, 18'd0,  1'b0},
      '{32'sd0,        1'b0, 1'b0, 18'd0,  1'b0},
      '{32'sd0,        1'b0, 1'b0, 18'd0,  1'b0},
      '{32'sd1,        1'b0, 1'b0, 18'd0,  1'b0},
      '{-32'sd2,       1'b0, 1'b0, 18'd0,  1'b0},
      '{32'h8000_0000, 1'b1, 1'b0, 18'd0,  1'b0},
      // equal value ends the first climb
      '{32'h7FFF_FFFF, 1'b0, 1'b0, 18'd0,  1'b0},
      '{32'h7FFF_FFFF, 1'b1, 1'b0, 18'd0,  1'b0}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   apa_pkg::corr_type  req_corr_value;
   logic               req_frame_end;
   logic               rsp_valid;
   logic               rsp_ready;
   apa_pkg::rate_type  rsp_pitch_hz;
   logic               rsp_distance_error;
   logic               rsp_mean_valid;
   apa_pkg::rate_type  rsp_mean_pitch;
   apa_pkg::upper_type rsp_upper_bound;
   apa_pkg::rate_type  rsp_lower_bound;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [3:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   // pitch tracker state and register shadows
   apa_pkg::phase_type est_phase      = apa_pkg::PH_FIRST_PEAK;
   apa_pkg::corr_type  est_peak       = '0;
   apa_pkg::idx_type   est_index      = apa_pkg::idx_type'(FRAME_LEN - 1);
   apa_pkg::idx_type   est_first_pos  = '0;
   apa_pkg::idx_type   est_second_pos = '0;
   logic [25:0]        est_sum        = '0;
   apa_pkg::byte_type  est_frames     = '0;
   apa_pkg::rate_type  cfg_rate       = apa_pkg::RESET_SAMPLE_RATE;
   apa_pkg::byte_type  cfg_div        = apa_pkg::RESET_THRESHOLD;
   apa_pkg::byte_type  cfg_window     = apa_pkg::RESET_FRAMES;

   pitch_report_type  pending_reports[$];
   pitch_report_type  arrived;
   apa_pkg::corr_type frame_vals[$];
   int                fault_count   = 0;
   int                items_sent    = 0;
   int                cycle_count   = 0;
   int                send_idle_pct = 0;
   int                stall_pct     = 0;
   int                hold_ask      = 0;

   autocorr_pitch_averager_unit #(
      .FRAME_LENGTH(FRAME_LEN)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_corr_value     (req_corr_value),
      .req_frame_end      (req_frame_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pitch_hz       (rsp_pitch_hz),
      .rsp_distance_error (rsp_distance_error),
      .rsp_mean_valid     (rsp_mean_valid),
      .rsp_mean_pitch     (rsp_mean_pitch),
      .rsp_upper_bound    (rsp_upper_bound),
      .rsp_lower_bound    (rsp_lower_bound),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Advance the tracker by one value; return 1 with the frame report on a frame end.
   function automatic bit step_pitch(input apa_pkg::corr_type v, input logic fe,
                                     output pitch_report_type rep);
      apa_pkg::idx_type pos;
      apa_pkg::idx_type span;
      logic [31:0]      mean_w;
      logic [31:0]      band_w;
      rep = '0;
      pos = est_index + 9'd1;
      case (est_phase)
         apa_pkg::PH_FIRST_PEAK: begin
            if (v > est_peak) begin
               est_peak = v;
            end else begin
               est_first_pos = pos;
               est_phase     = apa_pkg::PH_FALL;
            end
         end
         apa_pkg::PH_FALL: begin
            if (v < 0) est_phase = apa_pkg::PH_RISE;
         end
         apa_pkg::PH_RISE: begin
            if (v > 0) begin
               est_phase = apa_pkg::PH_SECOND_PEAK;
               est_peak  = '0;
            end
         end
         apa_pkg::PH_SECOND_PEAK: begin
            if (v > est_peak) begin
               est_peak = v;
            end else begin
               est_second_pos = pos;
               est_phase      = apa_pkg::PH_DONE;
            end
         end
         default: ;
      endcase
      if (!fe) begin
         // saturate at lag zero
         if (est_index != 0) est_index = est_index - 9'd1;
         return 1'b0;
      end
      span = (est_first_pos >= est_second_pos) ? est_first_pos - est_second_pos : '0;
      if (span == 0) begin
         rep.err = 1'b1;
      end else begin
         rep.pitch = cfg_rate / span;
      end
      est_sum    = est_sum + rep.pitch;
      est_frames = est_frames + 8'd1;
      if (est_frames >= cfg_window && est_frames != 0) begin
         mean_w      = est_sum / est_frames;
         band_w      = (cfg_div != 0) ? mean_w / cfg_div : 32'd0;
         rep.mean_ok = 1'b1;
         rep.mean    = mean_w[17:0];
         rep.upper   = apa_pkg::upper_type'(mean_w + band_w);
         rep.lower   = apa_pkg::rate_type'(mean_w - band_w);
         est_sum     = '0;
         est_frames  = '0;
      end
      est_phase      = apa_pkg::PH_FIRST_PEAK;
      est_peak       = '0;
      est_index      = apa_pkg::idx_type'(FRAME_LEN - 1);
      est_first_pos  = '0;
      est_second_pos = '0;
      return 1'b1;
   endfunction

   function automatic apa_pkg::corr_type rand_corr();
      case ($urandom_range(19))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         default: return apa_pkg::corr_type'($urandom);
      endcase
   endfunction

   function automatic int fill_len();
      return ($urandom_range(9) == 0) ? $urandom_range(4, 60) : $urandom_range(0, 3);
   endfunction

   // Climb of rising positive values closed by one that is not above the peak.
   task automatic push_peak();
      apa_pkg::corr_type level;
      level = '0;
      repeat ($urandom_range(0, 4)) begin
         level = level + apa_pkg::corr_type'($urandom_range(1, 32'h0FFF_FFFF));
         frame_vals.push_back(level);
      end
      frame_vals.push_back(level - apa_pkg::corr_type'($urandom_range(0, 32'h0FFF_FFFF)));
   endtask

   task automatic build_frame(input bit tiny);
      apa_pkg::corr_type x;
      int                cut;
      int                target;
      frame_vals.delete();
      if (tiny) begin
         repeat ($urandom_range(1, 2)) frame_vals.push_back(rand_corr());
         return;
      end
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(1, 20)) frame_vals.push_back(rand_corr());
         return;
      end
      push_peak();
      repeat (fill_len())
         frame_vals.push_back(apa_pkg::corr_type'($urandom_range(0, 32'h7FFF_FFFF)));
      x = $urandom_range(1, 32'h7FFF_FFFF);
      frame_vals.push_back(($urandom_range(9) == 0) ?
                           apa_pkg::corr_type'(32'h8000_0000) : -x);
      repeat (fill_len())
         frame_vals.push_back(-apa_pkg::corr_type'($urandom_range(0, 32'h7FFF_FFFF)));
      frame_vals.push_back(apa_pkg::corr_type'($urandom_range(1, 32'h7FFF_FFFF)));
      push_peak();
      repeat ($urandom_range(0, 8)) frame_vals.push_back(rand_corr());
      // break the sequence off early now and then
      if ($urandom_range(99) < 15) begin
         cut = $urandom_range(1, frame_vals.size());
         while (frame_vals.size() > cut) void'(frame_vals.pop_back());
      end
      // stretch near or past the frame length so the lag may saturate
      if ($urandom_range(99) < 3) begin
         target = $urandom_range(250, 300);
         while (frame_vals.size() < target) frame_vals.push_back(rand_corr());
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input apa_pkg::corr_type v, input logic fe, output bit made);
      pitch_report_type rep;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_corr_value <= v;
      req_frame_end  <= fe;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      made = step_pitch(v, fe, rep);
      if (made) pending_reports.push_back(rep);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid, drain every pending report, then let the divider finish.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         apa_pkg::REG_SAMPLE_RATE: cfg_rate   = data[17:0];
         apa_pkg::REG_THRESHOLD:   cfg_div    = data[7:0];
         apa_pkg::REG_FRAMES:      cfg_window = data[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_setting(input apa_pkg::rate_type rate, input apa_pkg::byte_type div,
                                input apa_pkg::byte_type window);
      write_reg(apa_pkg::REG_SAMPLE_RATE, {14'd0, rate});
      write_reg(apa_pkg::REG_THRESHOLD, {24'd0, div});
      write_reg(apa_pkg::REG_FRAMES, {24'd0, window});
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   function automatic void check_field(input string name, input int unsigned want_v,
                                       input int unsigned got_v);
      if (want_v != got_v) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
         fault_count++;
      end
   endfunction

   initial begin : rsp_drive
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask > 0) begin
            hold_left = hold_ask;
            hold_ask  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: result with no pending frame end, expected none got pitch_hz %0d",
                     $time, rsp_pitch_hz);
            fault_count++;
         end else begin
            arrived = pending_reports.pop_front();
            check_field("pitch_hz", arrived.pitch, rsp_pitch_hz);
            check_field("distance_error", arrived.err, rsp_distance_error);
            check_field("mean_valid", arrived.mean_ok, rsp_mean_valid);
            check_field("mean_pitch", arrived.mean, rsp_mean_pitch);
            check_field("upper_bound", arrived.upper, rsp_upper_bound);
            check_field("lower_bound", arrived.lower, rsp_lower_bound);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("autocorr_pitch_averager_unit verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type     row;
      pitch_report_type typed_rep;
      bit               made;
      int               frames;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_corr_value = '0;
      req_frame_end  = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         send_item(row.value, row.last, made);
         if (made && row.typed) begin
            typed_rep       = '0;
            typed_rep.pitch = row.pitch;
            typed_rep.err   = row.err;
            pending_reports[pending_reports.size() - 1] = typed_rep;
         end
      end

      for (int p = 0; p < 6 || items_sent < ITEM_TARGET; p++) begin
         settle();
         case (p)
            0: apply_setting(18'd200000, 8'd1, 8'd1);
            1: apply_setting(18'd1, 8'd255, 8'd2);
            2: apply_setting(18'd44100, 8'd0, 8'd0);
            3: apply_setting(apa_pkg::rate_type'($urandom_range(1, 200000)),
                             apa_pkg::byte_type'($urandom_range(0, 255)), 8'd255);
            4: apply_setting(apa_pkg::rate_type'($urandom_range(1, 200000)),
                             apa_pkg::byte_type'($urandom_range(0, 255)), 8'd200);
            // lowered window: count already past it, so the next frame closes it
            5: apply_setting(apa_pkg::rate_type'($urandom_range(1, 200000)),
                             apa_pkg::byte_type'($urandom_range(0, 255)), 8'd3);
            default: apply_setting(apa_pkg::rate_type'($urandom_range(1, 200000)),
                                   apa_pkg::byte_type'($urandom_range(0, 255)),
                                   apa_pkg::byte_type'($urandom_range(0, 12)));
         endcase
         send_idle_pct = (p % 4 == 1) ? 63 : (p % 4 == 3) ? 15 : 0;
         stall_pct     = (p % 4 == 2) ? 63 : (p % 4 == 3) ? 15 : 0;
         // hold the result side so the block fills and stalls its input
         if (p == 2) hold_ask = HOLD_CYCLES;
         frames = (p == 3) ? 260 : $urandom_range(6, 14);
         repeat (frames) begin
            build_frame(p == 3);
            foreach (frame_vals[i]) send_item(frame_vals[i], i == frame_vals.size() - 1, made);
         end
      end

      settle();
      if (fault_count == 0) begin
         $display("autocorr_pitch_averager_unit verification clean");
      end else begin
         $display("autocorr_pitch_averager_unit verification failed");
      end
      $finish;
   end

endmodule
